[hdl/wvd_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the wind vector block.
`timescale 1ns / 1ps

package wvd_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DELAY_BITS_DEF    = 12;

    localparam int FIELD_W   = 13;   // raw delay field, two's complement
    localparam int SCALE_W   = 24;   // speed scale register
    localparam int ANGLE_W   = 12;
    localparam int SPEED_W   = 16;
    localparam int FRAC_W    = 16;   // fraction bits of x, y and z
    localparam int ZW        = 28;   // signed angle accumulator
    localparam int AW        = 28;   // unsigned full-circle angle
    localparam int INV_W     = 30;
    localparam int TABLE_LEN = 24;

    // 1/K in Q30
    localparam logic [INV_W-1:0] INV_GAIN = 30'd652032874;

    // angles in tenths of a degree, Q16
    localparam logic [AW-1:0] QUARTER_Q16 = 28'd58982400;
    localparam logic [AW-1:0] HALF_Q16    = 28'd117964800;
    localparam logic [AW-1:0] FULL_Q16    = 28'd235929600;

    localparam logic [ANGLE_W:0] FULL_TENTHS = 13'd3600;

    // speed in Q32 below this is under 0.1 m/s
    localparam logic [31:0] CALM_LIMIT = 32'd429496730;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
    } t_quad;

    // atan(2^-i) in tenths of a degree, Q16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 28'sd29491200;
            1:  v = 28'sd17409672;
            2:  v = 28'sd9198793;
            3:  v = 28'sd4669451;
            4:  v = 28'sd2343786;
            5:  v = 28'sd1173036;
            6:  v = 28'sd586661;
            7:  v = 28'sd293348;
            8:  v = 28'sd146676;
            9:  v = 28'sd73339;
            10: v = 28'sd36669;
            11: v = 28'sd18335;
            12: v = 28'sd9167;
            13: v = 28'sd4584;
            14: v = 28'sd2292;
            15: v = 28'sd1146;
            16: v = 28'sd573;
            17: v = 28'sd286;
            18: v = 28'sd143;
            19: v = 28'sd72;
            20: v = 28'sd36;
            21: v = 28'sd18;
            22: v = 28'sd9;
            23: v = 28'sd4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/wvd_front.sv]
// Front end: takes delay sets, drops unmeasured ones, forms axis magnitudes and quadrant.
`timescale 1ns / 1ps

module wvd_front #(
    parameter int DELAY_BITS = wvd_pkg::DELAY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [wvd_pkg::FIELD_W-1:0] i_delay_ab,
    input  logic [wvd_pkg::FIELD_W-1:0] i_delay_ba,
    input  logic [wvd_pkg::FIELD_W-1:0] i_delay_cd,
    input  logic [wvd_pkg::FIELD_W-1:0] i_delay_dc,
    input  logic                        i_queue_full,
    output logic                        o_busy,
    output logic                        o_push,
    output logic [DELAY_BITS-1:0]       o_x_mag,
    output logic [DELAY_BITS-1:0]       o_y_mag,
    output wvd_pkg::t_quad              o_quad
);

    localparam int FW = wvd_pkg::FIELD_W;

    logic [FW-1:0]         w_raw [4];
    logic [DELAY_BITS-1:0] w_sat [4];
    logic [3:0]            w_neg;

    logic signed [DELAY_BITS:0] w_dx, w_dy;

    logic                  r_valid;
    logic [DELAY_BITS-1:0] r_x_mag, r_y_mag;
    wvd_pkg::t_quad        r_quad;

    assign w_raw[0] = i_delay_ab;
    assign w_raw[1] = i_delay_ba;
    assign w_raw[2] = i_delay_cd;
    assign w_raw[3] = i_delay_dc;

    // sign check and clip of each delay to the configured range
    for (genvar g = 0; g < 4; g++) begin : g_delay
        assign w_neg[g] = w_raw[g][FW-1];
        if (DELAY_BITS >= FW - 1) begin : g_wide
            assign w_sat[g] = DELAY_BITS'(w_raw[g][FW-2:0]);
        end else begin : g_clip
            assign w_sat[g] = (|w_raw[g][FW-2:DELAY_BITS]) ? '1
                                                          : w_raw[g][DELAY_BITS-1:0];
        end
    end

    assign w_dx = $signed({1'b0, w_sat[0]}) - $signed({1'b0, w_sat[1]});
    assign w_dy = $signed({1'b0, w_sat[3]}) - $signed({1'b0, w_sat[2]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= ~|w_neg;
        end else if (!i_queue_full) begin
            r_valid <= 1'b0;
        end
        if (i_take) begin
            r_quad.x_neg <= w_dx[DELAY_BITS];
            r_quad.y_neg <= w_dy[DELAY_BITS];
            r_x_mag <= w_dx[DELAY_BITS] ? DELAY_BITS'(-w_dx) : w_dx[DELAY_BITS-1:0];
            r_y_mag <= w_dy[DELAY_BITS] ? DELAY_BITS'(-w_dy) : w_dy[DELAY_BITS-1:0];
        end
    end

    assign o_busy  = r_valid & i_queue_full;
    assign o_push  = r_valid & ~i_queue_full;
    assign o_x_mag = r_x_mag;
    assign o_y_mag = r_y_mag;
    assign o_quad  = r_quad;

endmodule

[hdl/wvd_queue.sv]
// Two-entry item queue between the front end and the CORDIC back end.
`timescale 1ns / 1ps

module wvd_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count;
    logic         w_pop;

    assign w_pop = i_pop & (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[hdl/wvd_cordic.sv]
// Pipelined vectoring CORDIC, one iteration per stage, first quadrant.
`timescale 1ns / 1ps

module wvd_cordic #(
    parameter int CORDIC_STAGES = wvd_pkg::CORDIC_STAGES_DEF,
    parameter int DELAY_BITS    = wvd_pkg::DELAY_BITS_DEF,
    parameter int CW            = DELAY_BITS + 19
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [DELAY_BITS-1:0]           i_x_mag,
    input  logic [DELAY_BITS-1:0]           i_y_mag,
    input  wvd_pkg::t_quad                  i_quad,
    output logic                            o_valid,
    output logic signed [CW-1:0]            o_x,
    output logic signed [wvd_pkg::ZW-1:0]   o_z,
    output wvd_pkg::t_quad                  o_quad
);

    localparam int ZW  = wvd_pkg::ZW;
    localparam int PAD = CW - DELAY_BITS - wvd_pkg::FRAC_W;

    logic                 r_valid [CORDIC_STAGES];
    logic signed [CW-1:0] r_x     [CORDIC_STAGES];
    logic signed [CW-1:0] r_y     [CORDIC_STAGES];
    logic signed [ZW-1:0] r_z     [CORDIC_STAGES];
    wvd_pkg::t_quad       r_quad  [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic                 w_v;
        logic signed [CW-1:0] w_x, w_y, w_xs, w_ys, n_x, n_y;
        logic signed [ZW-1:0] w_z, n_z;
        wvd_pkg::t_quad       w_q;

        if (k == 0) begin : g_first
            assign w_v = i_valid;
            assign w_x = $signed({{PAD{1'b0}}, i_x_mag, {wvd_pkg::FRAC_W{1'b0}}});
            assign w_y = $signed({{PAD{1'b0}}, i_y_mag, {wvd_pkg::FRAC_W{1'b0}}});
            assign w_z = '0;
            assign w_q = i_quad;
        end else begin : g_next
            assign w_v = r_valid[k-1];
            assign w_x = r_x[k-1];
            assign w_y = r_y[k-1];
            assign w_z = r_z[k-1];
            assign w_q = r_quad[k-1];
        end

        // floor shifts of the signed values
        assign w_xs = w_x >>> k;
        assign w_ys = w_y >>> k;

        always_comb begin
            if (!w_y[CW-1]) begin
                n_x = w_x + w_ys;
                n_y = w_y - w_xs;
                n_z = w_z + wvd_pkg::atan_q16(k);
            end else begin
                n_x = w_x - w_ys;
                n_y = w_y + w_xs;
                n_z = w_z - wvd_pkg::atan_q16(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_v;
            end
            r_x[k]    <= n_x;
            r_y[k]    <= n_y;
            r_z[k]    <= n_z;
            r_quad[k] <= w_q;
        end
    end

    assign o_valid = r_valid[CORDIC_STAGES-1];
    assign o_x     = r_x[CORDIC_STAGES-1];
    assign o_z     = r_z[CORDIC_STAGES-1];
    assign o_quad  = r_quad[CORDIC_STAGES-1];

endmodule

[hdl/wvd_post.sv]
// Back end tail: gain removal, speed scaling and rounding, angle quadrant mapping.
`timescale 1ns / 1ps

module wvd_post #(
    parameter int CW = wvd_pkg::DELAY_BITS_DEF + 19
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [CW-1:0]            i_x,
    input  logic signed [wvd_pkg::ZW-1:0]   i_z,
    input  wvd_pkg::t_quad                  i_quad,
    input  logic [wvd_pkg::SCALE_W-1:0]     i_scale,
    output logic                            o_valid,
    output logic [wvd_pkg::ANGLE_W-1:0]     o_angle,
    output logic [wvd_pkg::SPEED_W-1:0]     o_speed,
    output logic                            o_calm
);

    localparam int ZW  = wvd_pkg::ZW;
    localparam int AW  = wvd_pkg::AW;
    localparam int AGW = wvd_pkg::ANGLE_W;
    localparam int SPW = wvd_pkg::SPEED_W;
    localparam int MW  = CW - 1;                    // magnitude, and unsigned x
    localparam int PW  = MW + wvd_pkg::INV_W;       // x * 1/K
    localparam int SW  = MW + wvd_pkg::SCALE_W;     // speed, Q32 m/s
    localparam int HW  = SW + 7;                    // speed * 100

    localparam logic [PW:0]   MAG_RND = (PW + 1)'(1) << 29;
    localparam logic [AW:0]   ANG_RND = (AW + 1)'(1) << 15;
    localparam logic [HW:0]   HUN_RND = (HW + 1)'(1) << 31;

    // stage 1
    logic                r1_valid;
    logic [PW-1:0]       r1_prod;
    logic [AW-1:0]       r1_ang;
    logic [MW-1:0]       w_x_u;
    logic [AW-1:0]       w_zc, n_ang;
    // stage 2
    logic                r2_valid;
    logic [MW-1:0]       r2_mag;
    logic [AGW-1:0]      r2_tenths;
    logic [PW:0]         w_mag_sum;
    logic [AW:0]         w_ang_sum;
    logic [AGW:0]        w_tenths;
    // stage 3
    logic                r3_valid;
    logic [SW-1:0]       r3_spd;
    logic [AGW-1:0]      r3_tenths;
    // stage 4
    logic                r4_valid;
    logic [HW-1:0]       r4_spd100;
    logic                r4_calm;
    logic [AGW-1:0]      r4_tenths;
    // stage 5
    logic [HW:0]         w_hun_sum;
    logic [SW-25:0]      w_hun;
    logic                r_valid;
    logic [AGW-1:0]      r_angle;
    logic [SPW-1:0]      r_speed;
    logic                r_calm;

    assign w_x_u = i_x[CW-1] ? '0 : i_x[MW-1:0];

    // clamp to the first quadrant, then place in the quadrant of (dx, dy)
    always_comb begin
        if (i_z[ZW-1]) begin
            w_zc = '0;
        end else if (AW'(i_z) > wvd_pkg::QUARTER_Q16) begin
            w_zc = wvd_pkg::QUARTER_Q16;
        end else begin
            w_zc = AW'(i_z);
        end
        case ({i_quad.x_neg, i_quad.y_neg})
            2'b00:   n_ang = w_zc;
            2'b10:   n_ang = wvd_pkg::HALF_Q16 - w_zc;
            2'b11:   n_ang = wvd_pkg::HALF_Q16 + w_zc;
            2'b01:   n_ang = wvd_pkg::FULL_Q16 - w_zc;
            default: n_ang = w_zc;
        endcase
    end

    assign w_mag_sum = {1'b0, r1_prod} + MAG_RND;
    assign w_ang_sum = {1'b0, r1_ang} + ANG_RND;
    assign w_tenths  = w_ang_sum[AW:16];

    assign w_hun_sum = {1'b0, r4_spd100} + HUN_RND;
    assign w_hun     = w_hun_sum[HW:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r_valid  <= r4_valid;
        end

        r1_prod   <= PW'(w_x_u * wvd_pkg::INV_GAIN);
        r1_ang    <= n_ang;

        r2_mag    <= w_mag_sum[30 +: MW];
        r2_tenths <= (w_tenths >= wvd_pkg::FULL_TENTHS) ? '0 : w_tenths[AGW-1:0];

        r3_spd    <= SW'(r2_mag * i_scale);
        r3_tenths <= r2_tenths;

        r4_spd100 <= ({r3_spd, 6'b0} + {1'b0, r3_spd, 5'b0}) + {4'b0, r3_spd, 2'b0};
        r4_calm   <= r3_spd < SW'(wvd_pkg::CALM_LIMIT);
        r4_tenths <= r3_tenths;

        r_speed   <= (|w_hun[SW-25:SPW]) ? wvd_pkg::SPEED_MAX : w_hun[SPW-1:0];
        r_calm    <= r4_calm;
        r_angle   <= r4_calm ? '0 : r4_tenths;
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;
    assign o_speed = r_speed;
    assign o_calm  = r_calm;

endmodule

[hdl/wind_vector_from_delays.sv]
// Top level: wind speed and direction from four acoustic time-of-flight delays.
//
// Usage
//   Items: raise start with the four delays; the item is taken at a rising edge
//   where start is high and busy is low. An item with any negative delay (not
//   yet measured) is dropped and gives no result.
//   Results: o_result_valid is high for exactly one cycle with angle, speed and
//   calm; the receiver must take it then, it cannot stall the block.
//   Configuration: i_cfg_valid / o_cfg_ready write speed_scale (Q16 m/s per
//   tick). o_cfg_ready is always high; write only while no items are in flight.
//   Throughput: one item per cycle. busy stays low in normal use, since the
//   back end drains the two-entry queue every cycle.
//   Path: front register, queue, one CORDIC iteration per stage, then five
//   stages for gain removal, speed multiply, x100, rounding and saturation.
//   Reset (synchronous, active low): all pipeline valids clear, queue empties,
//   speed_scale returns to 0.
`timescale 1ns / 1ps

module wind_vector_from_delays #(
    parameter int CORDIC_STAGES = wvd_pkg::CORDIC_STAGES_DEF,   // 8..24
    parameter int DELAY_BITS    = wvd_pkg::DELAY_BITS_DEF       // 8..16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            start,
    output logic                            busy,
    input  logic [wvd_pkg::FIELD_W-1:0]     i_delay_ab,
    input  logic [wvd_pkg::FIELD_W-1:0]     i_delay_ba,
    input  logic [wvd_pkg::FIELD_W-1:0]     i_delay_cd,
    input  logic [wvd_pkg::FIELD_W-1:0]     i_delay_dc,
    // result output
    output logic                            o_result_valid,
    output logic [wvd_pkg::ANGLE_W-1:0]     o_angle_tenths,
    output logic [wvd_pkg::SPEED_W-1:0]     o_speed_hundredths,
    output logic                            o_calm,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wvd_pkg::SCALE_W-1:0]     i_cfg_data
);

    // x/y carry Q16 plus headroom for the CORDIC gain and sign
    localparam int CW = DELAY_BITS + 19;
    localparam int QW = 2 * DELAY_BITS + 2;

    logic [wvd_pkg::SCALE_W-1:0] r_speed_scale;

    logic                  w_take;
    logic                  w_push;
    logic [DELAY_BITS-1:0] w_x_mag, w_y_mag;
    wvd_pkg::t_quad        w_quad;

    logic                  w_q_full, w_q_valid;
    logic [QW-1:0]         w_q_data;
    logic [DELAY_BITS-1:0] w_q_x_mag, w_q_y_mag;
    wvd_pkg::t_quad        w_q_quad;

    logic                           w_c_valid;
    logic signed [CW-1:0]           w_c_x;
    logic signed [wvd_pkg::ZW-1:0]  w_c_z;
    wvd_pkg::t_quad                 w_c_quad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_speed_scale <= i_cfg_data;
        end
    end

    assign w_take = start & ~busy;

    wvd_front #(
        .DELAY_BITS (DELAY_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_delay_ab   (i_delay_ab),
        .i_delay_ba   (i_delay_ba),
        .i_delay_cd   (i_delay_cd),
        .i_delay_dc   (i_delay_dc),
        .i_queue_full (w_q_full),
        .o_busy       (busy),
        .o_push       (w_push),
        .o_x_mag      (w_x_mag),
        .o_y_mag      (w_y_mag),
        .o_quad       (w_quad)
    );

    // back end takes one item every cycle, so the queue pops whenever it holds one
    wvd_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_quad, w_x_mag, w_y_mag}),
        .i_pop   (w_q_valid),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_quad  = w_q_data[QW-1 -: 2];
    assign w_q_x_mag = w_q_data[2*DELAY_BITS-1 -: DELAY_BITS];
    assign w_q_y_mag = w_q_data[DELAY_BITS-1:0];

    wvd_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .DELAY_BITS    (DELAY_BITS),
        .CW            (CW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_x_mag (w_q_x_mag),
        .i_y_mag (w_q_y_mag),
        .i_quad  (w_q_quad),
        .o_valid (w_c_valid),
        .o_x     (w_c_x),
        .o_z     (w_c_z),
        .o_quad  (w_c_quad)
    );

    wvd_post #(
        .CW (CW)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .i_x     (w_c_x),
        .i_z     (w_c_z),
        .i_quad  (w_c_quad),
        .i_scale (r_speed_scale),
        .o_valid (o_result_valid),
        .o_angle (o_angle_tenths),
        .o_speed (o_speed_hundredths),
        .o_calm  (o_calm)
    );

endmodule

[tb/tb_top.sv]
// Self-checking bench for wind_vector_from_delays: delay sets in, wind angle/speed/calm checked.
`timescale 1ns / 1ps

module tb_top;

    localparam int CORDIC_DEPTH = wvd_pkg::CORDIC_STAGES_DEF;
    localparam longint DLY_MAX  = (64'd1 << wvd_pkg::DELAY_BITS_DEF) - 1;
    localparam int PIPE_LAT     = CORDIC_DEPTH + 7;
    localparam int SETTLE       = PIPE_LAT + 8;      // quiet cycles before a scale write
    localparam int unsigned CYCLE_LIMIT = 200000;

    // angles in tenths of a degree, 16 fraction bits
    localparam longint QUARTER_TQ = 64'd900 * 64'd65536;
    localparam longint HALF_TQ    = 64'd1800 * 64'd65536;
    localparam longint FULL_TQ    = 64'd3600 * 64'd65536;

    typedef longint unsigned t_u64;

    localparam t_u64 INV_GAIN_Q30 = 64'd652032874;   // 1/K, Q30

    typedef struct packed {
        logic [wvd_pkg::FIELD_W-1:0] ab;
        logic [wvd_pkg::FIELD_W-1:0] ba;
        logic [wvd_pkg::FIELD_W-1:0] cd;
        logic [wvd_pkg::FIELD_W-1:0] dc;
    } t_delay_set;

    typedef struct packed {
        logic [wvd_pkg::ANGLE_W-1:0] angle;
        logic [wvd_pkg::SPEED_W-1:0] speed;
        logic                        calm;
    } t_wind;

    // atan(2^-i), tenths of a degree, Q16
    longint atan_tab [0:15] = '{
        29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
        146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146
    };

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                        start      = 1'b0;
    logic                        busy;
    logic [wvd_pkg::FIELD_W-1:0] i_delay_ab = '0;
    logic [wvd_pkg::FIELD_W-1:0] i_delay_ba = '0;
    logic [wvd_pkg::FIELD_W-1:0] i_delay_cd = '0;
    logic [wvd_pkg::FIELD_W-1:0] i_delay_dc = '0;

    logic                        o_result_valid;
    logic [wvd_pkg::ANGLE_W-1:0] o_angle_tenths;
    logic [wvd_pkg::SPEED_W-1:0] o_speed_hundredths;
    logic                        o_calm;

    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [wvd_pkg::SCALE_W-1:0] i_cfg_data  = '0;

    // bench state
    t_delay_set delay_backlog [$];   // sets waiting to be driven
    t_wind      wind_due [$];        // predicted results, oldest first
    t_delay_set cur_set;
    logic [wvd_pkg::SCALE_W-1:0] scale_model = '0;
    int          n_queued    = 0;
    int          n_accepted  = 0;
    int          idle_pct    = 0;    // chance of an idle burst after each item
    int          idle_left   = 0;
    int          n_errors    = 0;
    int unsigned cycle_cnt   = 0;

    wind_vector_from_delays dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_delay_ab        (i_delay_ab),
        .i_delay_ba        (i_delay_ba),
        .i_delay_cd        (i_delay_cd),
        .i_delay_dc        (i_delay_dc),
        .o_result_valid    (o_result_valid),
        .o_angle_tenths    (o_angle_tenths),
        .o_speed_hundredths(o_speed_hundredths),
        .o_calm            (o_calm),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // sign-extend a raw field; nonnegative values saturate to the delay range
    function automatic longint clip_delay(input logic [wvd_pkg::FIELD_W-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > DLY_MAX) v = DLY_MAX;
        return v;
    endfunction

    // returns 0 when the set holds an unmeasured delay (no result)
    function automatic bit wind_predict(input t_delay_set d, output t_wind w);
        longint ab, ba, cd, dc, dx, dy, x, y, z, xs, ys, ang;
        t_u64   mag, spd, hund, tenths;
        bit     is_calm;
        int     i;
        w  = '0;
        ab = clip_delay(d.ab);
        ba = clip_delay(d.ba);
        cd = clip_delay(d.cd);
        dc = clip_delay(d.dc);
        if (ab < 0 || ba < 0 || cd < 0 || dc < 0) return 1'b0;
        dx = ab - ba;
        dy = dc - cd;

        // vectoring CORDIC on the first-quadrant image, Q16
        x = (dx < 0 ? -dx : dx) * 65536;
        y = (dy < 0 ? -dy : dy) * 65536;
        z = 0;
        for (i = 0; i < CORDIC_DEPTH; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += atan_tab[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_tab[i];
            end
        end
        if (x < 0) x = 0;
        if (z < 0) z = 0;
        if (z > QUARTER_TQ) z = QUARTER_TQ;

        // gain removal, scale, rounding to hundredths
        mag     = (t_u64'(x) * INV_GAIN_Q30 + (64'd1 << 29)) >> 30;
        spd     = mag * t_u64'(scale_model);
        is_calm = (spd * 10) < (64'd1 << 32);
        if ((spd >> 32) >= 656) hund = 65535;
        else begin
            hund = (spd * 100 + (64'd1 << 31)) >> 32;
            if (hund > 65535) hund = 65535;
        end

        // quadrant mapping, full circle wraps to 0
        if (is_calm) tenths = 0;
        else begin
            if (dx >= 0 && dy >= 0) ang = z;
            else if (dx < 0 && dy >= 0) ang = HALF_TQ - z;
            else if (dx < 0) ang = HALF_TQ + z;
            else ang = FULL_TQ - z;
            tenths = (t_u64'(ang) + 32768) >> 16;
            if (tenths >= 3600) tenths = 0;
        end

        w.angle = tenths[wvd_pkg::ANGLE_W-1:0];
        w.speed = hund[wvd_pkg::SPEED_W-1:0];
        w.calm  = is_calm;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one item per handshake, random idle bursts between items
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic  next_start;
        t_wind w;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            next_start = start;
            // item taken at this edge
            if (start && !busy) begin
                if (wind_predict(cur_set, w)) wind_due.push_back(w);
                n_accepted++;
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (idle_left > 0) idle_left <= idle_left - 1;
                else if (delay_backlog.size() > 0) begin
                    cur_set = delay_backlog.pop_front();
                    i_delay_ab <= cur_set.ab;
                    i_delay_ba <= cur_set.ba;
                    i_delay_cd <= cur_set.cd;
                    i_delay_dc <= cur_set.dc;
                    next_start = 1'b1;
                    if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                        idle_left <= $urandom_range(11, 1);
                end
            end
            start <= next_start;   // single update per edge
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results cannot be held off, so every strobe is checked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_wind e;
        if (i_rst_n && o_result_valid) begin
            if (wind_due.size() == 0) begin
                $display("%0t: unexpected result: angle %0d speed %0d calm %0d",
                         $time, o_angle_tenths, o_speed_hundredths, o_calm);
                n_errors++;
            end else begin
                e = wind_due.pop_front();
                if (o_angle_tenths !== e.angle) begin
                    $display("%0t: angle_tenths expected %0d got %0d",
                             $time, e.angle, o_angle_tenths);
                    n_errors++;
                end
                if (o_speed_hundredths !== e.speed) begin
                    $display("%0t: speed_hundredths expected %0d got %0d",
                             $time, e.speed, o_speed_hundredths);
                    n_errors++;
                end
                if (o_calm !== e.calm) begin
                    $display("%0t: calm expected %0d got %0d", $time, e.calm, o_calm);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_set(input int ab, input int ba, input int cd, input int dc);
        t_delay_set s;
        s.ab = 13'(ab);
        s.ba = 13'(ba);
        s.cd = 13'(cd);
        s.dc = 13'(dc);
        delay_backlog.push_back(s);
        n_queued++;
    endtask

    // mostly measured sets of varied shape; about a sixth carry a missing delay
    task automatic queue_random(input int n);
        int f [4];
        int base;
        int k;
        repeat (n) begin
            case ($urandom_range(11))
                0, 1, 2: begin   // anywhere in range
                    for (k = 0; k < 4; k++) f[k] = $urandom_range(4095);
                end
                3, 4: begin      // near-equal delays: short vectors, calm region
                    base = $urandom_range(4095);
                    for (k = 0; k < 4; k++) begin
                        f[k] = base + $urandom_range(24) - 12;
                        if (f[k] < 0) f[k] = 0;
                        if (f[k] > 4095) f[k] = 4095;
                    end
                end
                5: begin         // on an axis
                    for (k = 0; k < 4; k++) f[k] = $urandom_range(4095);
                    if ($urandom_range(1)) f[1] = f[0];
                    else f[3] = f[2];
                end
                6: begin         // rail values only
                    for (k = 0; k < 4; k++) f[k] = $urandom_range(1) ? 4095 : 0;
                end
                7, 8, 9: begin   // one axis nearly zero, angle near an axis
                    for (k = 0; k < 4; k++) f[k] = $urandom_range(4095);
                    base = $urandom_range(1) ? 2 : 0;
                    f[base + 1] = f[base] + $urandom_range(6) - 3;
                    if (f[base + 1] < 0) f[base + 1] = 0;
                    if (f[base + 1] > 4095) f[base + 1] = 4095;
                end
                default: begin   // not yet measured: at least one negative delay
                    for (k = 0; k < 4; k++) f[k] = $urandom_range(8191) - 4096;
                    f[$urandom_range(3)] = -1 - $urandom_range(4095);
                end
            endcase
            queue_set(f[0], f[1], f[2], f[3]);
        end
    endtask

    task automatic write_scale(input logic [wvd_pkg::SCALE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        scale_model = v;
    endtask

    // all queued items taken, all results seen, pipeline empty of dropped items
    task automatic drain();
        while (n_accepted != n_queued || wind_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [wvd_pkg::SCALE_W-1:0] scale, input int pct,
                             input int n);
        write_scale(scale);
        idle_pct = pct;
        queue_random(n);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sets at 0.01 m/s per tick
        write_scale(24'd655);
        idle_pct = 20;
        queue_set(0, 0, 0, 0);              // zero vector
        queue_set(4095, 4095, 4095, 4095);  // zero vector at the top rail
        queue_set(4095, 0, 0, 0);           // east
        queue_set(0, 4095, 0, 0);           // west: dy 0, dx negative
        queue_set(0, 0, 0, 4095);           // north
        queue_set(0, 0, 4095, 0);           // south: dx 0, dy negative
        queue_set(4095, 0, 0, 4095);        // the four diagonals
        queue_set(0, 4095, 0, 4095);
        queue_set(0, 4095, 4095, 0);
        queue_set(4095, 0, 4095, 0);
        queue_set(4095, 0, 1, 0);           // just below east: rounds to a full circle
        queue_set(0, 4095, 1, 0);           // just below west
        queue_set(1, 0, 0, 4095);           // near north: first-quadrant angle clamp
        queue_set(0, 0, 0, 1);              // one tick: calm
        queue_set(10, 0, 0, 0);             // around the calm threshold
        queue_set(11, 0, 0, 0);
        queue_set(2048, 2047, 1365, 2730);
        queue_set(-1, 0, 0, 0);             // unmeasured delay in each field
        queue_set(0, -1, 0, 0);
        queue_set(0, 0, -1, 0);
        queue_set(0, 0, 0, -1);
        queue_set(-4096, -4096, -4096, -4096);
        queue_set(4095, -4096, 4095, 4095);
        queue_random(130);
        drain();

        run_phase(24'd0, 40, 60);                          // scale zero: all calm
        run_phase(24'hFFFFFF, 20, 80);                     // speed saturates
        run_phase(24'd1, 30, 60);                          // tiny scale
        run_phase(24'($urandom_range(70000, 2)), 25, 150); // mixed range
        run_phase(24'd6554, 0, 150);                       // no idling at the tail

        if (n_errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
